FILE: sv/lru_page_frame_directory_unit_macros.svh
// Assertion macros for the page frame directory.
// Used by lru_page_frame_directory_unit; expects clk and arst_n in scope.
`ifndef LRU_PAGE_FRAME_DIRECTORY_UNIT_MACROS_SVH
`define LRU_PAGE_FRAME_DIRECTORY_UNIT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock outside reset
`define LPFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be true outside reset
`define LPFD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define LPFD_ASSERT(lbl, prop, msg)
`define LPFD_NEVER(lbl, cond, msg)
`endif
`endif

FILE: sv/lpfd_pkg.sv
// Package for the page frame directory: constants, codes, transaction types.
// No dependencies.
package lpfd_pkg;
	localparam int LPFD_FRAMES       = 16;
	localparam int LPFD_PAGE_ID_BITS = 32;
	localparam int LPFD_MAX_RESULTS  = 16;
	localparam logic [7:0] PIN_MAX   = 8'hFF;

	typedef enum logic [2:0] {
		CMD_FETCH     = 3'd0,
		CMD_NEW       = 3'd1,
		CMD_DIRTY     = 3'd2,
		CMD_UNPIN     = 3'd3,
		CMD_FLUSH     = 3'd4,
		CMD_FLUSH_ALL = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_ALL_PINNED = 3'd1,
		ST_NOT_FOUND  = 3'd2,
		ST_NOT_PINNED = 3'd3,
		ST_PIN_LIMIT  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_WRITE = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_FEND,
		S_EXEC,
		S_FILL
	} state_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] page_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  frame_index;
		logic [1:0]  action;
		logic [31:0] action_page_id;
		logic        last;
	} rsp_t;

	// build one result transaction
	function automatic rsp_t mk_rsp(status_t st, logic [3:0] fr, action_t act,
		logic [31:0] pg, logic lst);
		rsp_t r;
		r.status         = st;
		r.frame_index    = fr;
		r.action         = act;
		r.action_page_id = pg;
		r.last           = lst;
		return r;
	endfunction
endpackage

FILE: sv/lpfd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module lpfd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: sv/lru_page_frame_directory_unit.sv
// LRU page frame directory: associative lookup, pinning and victim choice.
// Depends on lpfd_pkg, lpfd_ram and lru_page_frame_directory_unit_macros.svh.
//
// Usage: one command transaction enters on req (req_valid/req_stall); each
// command yields one or more result transactions on rsp (rsp_valid/rsp_stall),
// the final one flagged by last. Unknown command codes give no result.
// Page ids live in a FRAMES-deep RAM; every known command sweeps it once, each
// frame read (S_RD) and then compared (S_CHK), followed by a result step;
// a miss that fills a frame adds one more step (S_FILL).
// Flush-all emits one write per dirty frame (at most 16) as it sweeps.
// req_stall is high while a command is in progress; the next command is taken
// once the previous one has produced its last result into the output register.
// A stalled rsp holds its transaction; the sweep pauses when a new result
// finds the output register still occupied.
// Reset clears all valid, dirty, pin and rank state and the fill count; the
// page RAM needs no clearing since only valid frames are ever compared.
`include "lru_page_frame_directory_unit_macros.svh"
module lru_page_frame_directory_unit import lpfd_pkg::*; #(
	parameter int FRAMES       = LPFD_FRAMES,
	parameter int PAGE_ID_BITS = LPFD_PAGE_ID_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);
	localparam int FW = $clog2(FRAMES);
	localparam int TW = $clog2(FRAMES + 1);
	localparam int CW = $clog2(LPFD_MAX_RESULTS + 1);

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [PAGE_ID_BITS-1:0] pid_q;
	logic [FW-1:0] a_q;

	logic [FRAMES-1:0] valid_q, dirty_q;
	logic [7:0]        pins_q [FRAMES];
	logic [FW-1:0]     rec_q  [FRAMES];
	logic [TW-1:0]     taken_q;

	logic hit_q, vf_q, pend_q, drop_q, ov_q;
	logic [FW-1:0] hf_q, vic_q, pfr_q, fill_q;
	logic [PAGE_ID_BITS-1:0] hp_q, vp_q, ppg_q, rd;
	logic [CW-1:0] cnt_q;
	rsp_t out_q, res;

	logic slot, emit, ram_re, ram_we;
	logic is_get, free, fl_take, fl_hold, match, vic_better, last_a, go_fill;

	// page id store
	lpfd_ram #(.WIDTH(PAGE_ID_BITS), .DEPTH(FRAMES)) u_page_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q),
		.wdata(pid_q),
		.re   (ram_re),
		.raddr(a_q),
		.rdata(rd)
	);

	assign slot      = !ov_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = ov_q;
	assign rsp       = out_q;

	assign is_get     = (cmd_q == CMD_FETCH) || (cmd_q == CMD_NEW);
	assign free       = taken_q < TW'(FRAMES);
	assign last_a     = (a_q == FW'(FRAMES - 1));
	assign fl_take    = valid_q[a_q] && dirty_q[a_q] && (cnt_q < CW'(LPFD_MAX_RESULTS));
	assign fl_hold    = fl_take && pend_q && !slot;
	assign match      = valid_q[a_q] && (rd == pid_q) && !hit_q;
	assign vic_better = valid_q[a_q] && (pins_q[a_q] == 8'd0) &&
		(!vf_q || rec_q[a_q] > rec_q[vic_q]);
	assign go_fill    = is_get && !hit_q && (free || vf_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && req.cmd <= CMD_FLUSH_ALL) state_d = S_RD;
			end
			S_RD: state_d = S_CHK;
			S_CHK: begin
				if (!(cmd_q == CMD_FLUSH_ALL && fl_hold)) begin
					if (!last_a) state_d = S_RD;
					else if (cmd_q == CMD_FLUSH_ALL) state_d = S_FEND;
					else state_d = S_EXEC;
				end
			end
			S_FEND: begin
				if (slot) state_d = S_IDLE;
			end
			S_EXEC: begin
				if (slot) state_d = go_fill ? S_FILL : S_IDLE;
			end
			S_FILL: begin
				if (slot) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// result and RAM controls
	always_comb begin
		emit   = 1'b0;
		res    = '0;
		ram_re = (state_q == S_RD);
		ram_we = 1'b0;
		unique case (state_q)
			S_CHK: begin
				if (cmd_q == CMD_FLUSH_ALL && fl_take && pend_q && slot) begin
					emit = 1'b1;
					res  = mk_rsp(ST_OK, 4'(pfr_q), ACT_WRITE, 32'(ppg_q), 1'b0);
				end
			end
			S_FEND: begin
				if (slot) begin
					emit = 1'b1;
					res  = pend_q ? mk_rsp(ST_OK, 4'(pfr_q), ACT_WRITE, 32'(ppg_q), 1'b1)
						: mk_rsp(ST_OK, 4'd0, ACT_NONE, 32'd0, 1'b1);
				end
			end
			S_EXEC: begin
				if (slot) begin
					if (is_get) begin
						if (hit_q) begin
							emit = 1'b1;
							res  = mk_rsp((pins_q[hf_q] == PIN_MAX) ? ST_PIN_LIMIT : ST_OK,
								4'(hf_q), ACT_NONE, 32'd0, 1'b1);
						end else if (!free && !vf_q) begin
							emit = 1'b1;
							res  = mk_rsp(ST_ALL_PINNED, 4'd0, ACT_NONE, 32'd0, 1'b1);
						end else if (!free && dirty_q[vic_q]) begin
							emit = 1'b1;
							res  = mk_rsp(ST_OK, 4'(vic_q), ACT_WRITE, 32'(vp_q), 1'b0);
						end
					end else begin
						emit = 1'b1;
						if (!hit_q)
							res = mk_rsp(ST_NOT_FOUND, 4'd0, ACT_NONE, 32'd0, 1'b1);
						else if (cmd_q == CMD_FLUSH)
							res = dirty_q[hf_q]
								? mk_rsp(ST_OK, 4'(hf_q), ACT_WRITE, 32'(hp_q), 1'b1)
								: mk_rsp(ST_OK, 4'(hf_q), ACT_NONE, 32'd0, 1'b1);
						else if (pins_q[hf_q] == 8'd0)
							res = mk_rsp(ST_NOT_PINNED, 4'(hf_q), ACT_NONE, 32'd0, 1'b1);
						else
							res = mk_rsp(ST_OK, 4'(hf_q), ACT_NONE, 32'd0, 1'b1);
					end
				end
			end
			S_FILL: begin
				if (slot) begin
					emit   = 1'b1;
					ram_we = 1'b1;
					res    = (cmd_q == CMD_FETCH)
						? mk_rsp(ST_OK, 4'(fill_q), ACT_READ, 32'(pid_q), 1'b1)
						: mk_rsp(ST_OK, 4'(fill_q), ACT_NONE, 32'd0, 1'b1);
				end
			end
			default: ;
		endcase
	end

	// control state and frame tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			a_q     <= '0;
			valid_q <= '0;
			dirty_q <= '0;
			taken_q <= '0;
			hit_q   <= 1'b0;
			vf_q    <= 1'b0;
			pend_q  <= 1'b0;
			drop_q  <= 1'b0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			fill_q  <= '0;
			for (int g = 0; g < FRAMES; g++) begin
				pins_q[g] <= 8'd0;
				rec_q[g]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (emit) ov_q <= 1'b1;
			else if (!rsp_stall) ov_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					a_q    <= '0;
					hit_q  <= 1'b0;
					vf_q   <= 1'b0;
					pend_q <= 1'b0;
					cnt_q  <= '0;
				end
				S_CHK: begin
					if (cmd_q == CMD_FLUSH_ALL) begin
						if (!fl_hold) begin
							a_q <= a_q + FW'(1);
							if (fl_take) begin
								pend_q       <= 1'b1;
								dirty_q[a_q] <= 1'b0;
								cnt_q        <= cnt_q + CW'(1);
							end
						end
					end else begin
						a_q <= a_q + FW'(1);
						if (match) hit_q <= 1'b1;
						if (vic_better) vf_q <= 1'b1;
					end
				end
				S_EXEC: begin
					if (slot) begin
						if (is_get) begin
							if (hit_q) begin
								if (pins_q[hf_q] != PIN_MAX) begin
									// pin and promote to most recently used
									pins_q[hf_q] <= pins_q[hf_q] + 8'd1;
									if (cmd_q == CMD_NEW) dirty_q[hf_q] <= 1'b1;
									for (int g = 0; g < FRAMES; g++) begin
										if (FW'(g) != hf_q && valid_q[g] &&
											rec_q[g] < rec_q[hf_q])
											rec_q[g] <= rec_q[g] + FW'(1);
									end
									rec_q[hf_q] <= '0;
								end
							end else if (free) begin
								fill_q  <= FW'(FRAMES - 1) - taken_q[FW-1:0];
								taken_q <= taken_q + TW'(1);
								drop_q  <= 1'b0;
							end else if (vf_q) begin
								fill_q <= vic_q;
								drop_q <= 1'b1;
							end
						end else if (hit_q) begin
							if (cmd_q == CMD_FLUSH) dirty_q[hf_q] <= 1'b0;
							else if (pins_q[hf_q] != 8'd0) begin
								if (cmd_q == CMD_DIRTY) dirty_q[hf_q] <= 1'b1;
								else pins_q[hf_q] <= pins_q[hf_q] - 8'd1;
							end
						end
					end
				end
				S_FILL: begin
					if (slot) begin
						// evict (if any) and insert as most recently used
						for (int g = 0; g < FRAMES; g++) begin
							if (FW'(g) != fill_q && valid_q[g] &&
								!(drop_q && rec_q[g] > rec_q[fill_q]))
								rec_q[g] <= rec_q[g] + FW'(1);
						end
						rec_q[fill_q]   <= '0;
						valid_q[fill_q] <= 1'b1;
						dirty_q[fill_q] <= (cmd_q == CMD_NEW);
						pins_q[fill_q]  <= 8'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			cmd_q <= cmd_t'(req.cmd);
			pid_q <= PAGE_ID_BITS'(req.page_id);
		end
		if (state_q == S_CHK) begin
			if (cmd_q == CMD_FLUSH_ALL) begin
				if (fl_take && !fl_hold) begin
					pfr_q <= a_q;
					ppg_q <= rd;
				end
			end else begin
				if (match) begin
					hf_q <= a_q;
					hp_q <= rd;
				end
				if (vic_better) begin
					vic_q <= a_q;
					vp_q  <= rd;
				end
			end
		end
		if (emit) out_q <= res;
	end

	// a fresh frame is counted in S_EXEC, before S_FILL sets its valid bit
	`LPFD_ASSERT(a_taken_cap, taken_q <= TW'(FRAMES), "fill count beyond frame count")
	`LPFD_ASSERT(a_vcnt, state_q != S_FILL |-> $countones(valid_q) == int'(taken_q), "valid count off")
	`LPFD_ASSERT(a_fill_free, (state_q == S_FILL) |-> (!valid_q[fill_q] || drop_q), "filling a live frame")
	`LPFD_ASSERT(a_flush_cap, cnt_q <= CW'(LPFD_MAX_RESULTS), "flush result count overflow")
	`LPFD_NEVER(a_no_overwrite, emit && !slot, "result written over a held transaction")
endmodule
